[rtl/assert_macros.svh]
// assertion helpers for the rtl files, used by egcd_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/egcd_pkg.sv]
// ----------------------------------------------------------------------------
// egcd_pkg
// types and constants shared by the extended gcd block
// ----------------------------------------------------------------------------
package egcd_pkg;

  localparam int OPER_WIDTH        = 31;
  localparam int COEF_WIDTH        = 32;
  localparam int DATA_WIDTH_DEF    = 31;
  localparam int MAX_STEPS_DEF     = 50;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_UPD,
    S_DONE
  } egcd_state_e;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
  } egcd_cmd_t;

  typedef struct packed {
    logic r1_zero;
  } egcd_status_t;

endpackage

[rtl/egcd_if.sv]
// ----------------------------------------------------------------------------
// egcd_in_if / egcd_out_if
// valid/ready channels for operand pairs and gcd results
// ----------------------------------------------------------------------------
interface egcd_in_if;
  import egcd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OPER_WIDTH-1:0] first_operand;
  logic [OPER_WIDTH-1:0] second_operand;

  modport source (output valid, output first_operand, output second_operand, input ready);
  modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

interface egcd_out_if;
  import egcd_pkg::*;

  logic                         valid;
  logic                         ready;
  logic        [OPER_WIDTH-1:0] gcd_value;
  logic signed [COEF_WIDTH-1:0] coeff_larger;
  logic signed [COEF_WIDTH-1:0] coeff_smaller;
  logic                         operands_swapped;

  modport source (output valid, output gcd_value, output coeff_larger,
                  output coeff_smaller, output operands_swapped, input ready);
  modport sink   (input valid, input gcd_value, input coeff_larger,
                  input coeff_smaller, input operands_swapped, output ready);
endinterface

[rtl/egcd_datapath.sv]
// ----------------------------------------------------------------------------
// egcd_datapath
// remainder and coefficient registers, bit-serial divider with shift-add
// quotient products
// ----------------------------------------------------------------------------
module egcd_datapath #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  egcd_pkg::egcd_cmd_t                  cmd_i,
  input  logic [egcd_pkg::OPER_WIDTH-1:0]      first_operand_i,
  input  logic [egcd_pkg::OPER_WIDTH-1:0]      second_operand_i,
  output egcd_pkg::egcd_status_t               status_o,
  output logic [DATA_WIDTH-1:0]                gcd_o,
  output logic [egcd_pkg::COEF_WIDTH-1:0]      coeff_larger_o,
  output logic [egcd_pkg::COEF_WIDTH-1:0]      coeff_smaller_o,
  output logic                                 swapped_o
);
  import egcd_pkg::*;

  logic [DATA_WIDTH-1:0] op_a, op_b;
  logic                  swap;

  logic [DATA_WIDTH-1:0] r0_q, r1_q, rem_q, dvd_q;
  logic [COEF_WIDTH-1:0] x0_q, x1_q, y0_q, y1_q, accx_q, accy_q;
  logic                  swapped_q;

  logic [DATA_WIDTH:0]   shifted, diff;
  logic                  ge;
  logic [DATA_WIDTH-1:0] rem_d;
  logic [COEF_WIDTH-1:0] accx_d, accy_d;

  assign op_a = DATA_WIDTH'(first_operand_i);
  assign op_b = DATA_WIDTH'(second_operand_i);
  assign swap = op_a < op_b;

  // restoring division, one quotient bit per cycle, msb first
  assign shifted = {rem_q, dvd_q[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, r1_q};
  assign ge      = shifted >= {1'b0, r1_q};
  assign rem_d   = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];

  // horner form of q * x1 and q * y1, kept modulo 2^32
  assign accx_d = (accx_q << 1) + (ge ? x1_q : '0);
  assign accy_d = (accy_q << 1) + (ge ? y1_q : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r0_q      <= swap ? op_b : op_a;
      r1_q      <= swap ? op_a : op_b;
      x0_q      <= COEF_WIDTH'(1);
      x1_q      <= '0;
      y0_q      <= '0;
      y1_q      <= COEF_WIDTH'(1);
      swapped_q <= swap;
    end else if (cmd_i.div_init) begin
      rem_q  <= '0;
      dvd_q  <= r0_q;
      accx_q <= '0;
      accy_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      dvd_q  <= dvd_q << 1;
      accx_q <= accx_d;
      accy_q <= accy_d;
    end else if (cmd_i.update) begin
      r0_q <= r1_q;
      r1_q <= rem_q;
      x0_q <= x1_q;
      x1_q <= x0_q - accx_q;
      y0_q <= y1_q;
      y1_q <= y0_q - accy_q;
    end
  end

  assign status_o.r1_zero = (r1_q == '0);
  assign gcd_o            = r0_q;
  assign coeff_larger_o   = x0_q;
  assign coeff_smaller_o  = y0_q;
  assign swapped_o        = swapped_q;

endmodule

[rtl/egcd_ctrl.sv]
// ----------------------------------------------------------------------------
// egcd_ctrl
// sequencer for load, division steps, coefficient updates and result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module egcd_ctrl #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF,
  parameter int MAX_STEPS  = egcd_pkg::MAX_STEPS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   out_free_i,
  output logic                   out_load_o,
  input  egcd_pkg::egcd_status_t status_i,
  output egcd_pkg::egcd_cmd_t    cmd_o
);
  import egcd_pkg::*;

  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int BIT_W  = $clog2(DATA_WIDTH);

  egcd_state_e       state_q, state_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic              at_cap, last_bit;

  assign at_cap   = (steps_q == STEP_W'(MAX_STEPS));
  assign last_bit = (bit_q == BIT_W'(DATA_WIDTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      steps_q <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      steps_q <= steps_d;
      bit_q   <= bit_d;
    end
  end

  // next state and counters
  always_comb begin
    state_d = state_q;
    steps_d = steps_q;
    bit_d   = bit_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
          steps_d = '0;
        end
      end
      S_CHECK: begin
        bit_d = '0;
        if (status_i.r1_zero || at_cap) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        bit_d = bit_q + BIT_W'(1);
        if (last_bit) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        steps_d = steps_q + STEP_W'(1);
        state_d = S_CHECK;
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CHECK:  cmd_o.div_init = !(status_i.r1_zero || at_cap);
      S_DIV:    cmd_o.div_step = 1'b1;
      S_UPD:    cmd_o.update   = 1'b1;
      S_DONE:   out_load_o     = out_free_i;
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_div_nonzero, state_q == S_DIV, !status_i.r1_zero, "division by zero divisor")
  `ASSERT_IMPL(a_div_below_cap, state_q == S_DIV, steps_q < STEP_W'(MAX_STEPS), "step cap passed")
  `ASSERT_NEXT(a_upd_to_check, state_q == S_UPD, state_q == S_CHECK, "update not followed by check")
  `ASSERT_NEXT(a_steps_cleared, cmd_o.load, steps_q == '0, "step count not cleared on load")

endmodule

[rtl/extended_gcd.sv]
// ----------------------------------------------------------------------------
// extended_gcd
// extended euclidean algorithm: gcd and bezout coefficients of an operand pair
// ----------------------------------------------------------------------------
//  channel    dir   payload
//  in_chan_i  in    first_operand, second_operand
//  out_chan_o out   gcd_value, coeff_larger, coeff_smaller, operands_swapped
//
//  one pair is worked on at a time; it is loaded, then each euclid step (at most
//  MAX_STEPS) runs a check, a bit-serial division and a coefficient update,
//  and a final check leads to the hand-off; the divider takes one quotient bit
//  per cycle; at most 44 euclid steps at the default sizes
//  a finished result sits in the output register; a new pair is taken while
//  it waits, and the next result holds until that register is free
//  reset is asynchronous, active low, and clears control state only
// ----------------------------------------------------------------------------
module extended_gcd #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF,
  parameter int MAX_STEPS  = egcd_pkg::MAX_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  egcd_in_if.sink    in_chan_i,
  egcd_out_if.source out_chan_o
);
  import egcd_pkg::*;

  egcd_cmd_t             cmd;
  egcd_status_t          status;
  logic                  out_free, out_load;
  logic [DATA_WIDTH-1:0] gcd;
  logic [COEF_WIDTH-1:0] coeff_larger, coeff_smaller;
  logic                  swapped;

  logic                         out_valid_q;
  logic        [OPER_WIDTH-1:0] gcd_q;
  logic signed [COEF_WIDTH-1:0] coeff_larger_q, coeff_smaller_q;
  logic                         swapped_q;

  egcd_ctrl #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_STEPS  (MAX_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .in_ready_o (in_chan_i.ready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  egcd_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .first_operand_i  (in_chan_i.first_operand),
    .second_operand_i (in_chan_i.second_operand),
    .status_o         (status),
    .gcd_o            (gcd),
    .coeff_larger_o   (coeff_larger),
    .coeff_smaller_o  (coeff_smaller),
    .swapped_o        (swapped)
  );

  // output register frees up in the same cycle its transfer completes
  assign out_free = !out_valid_q || out_chan_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      gcd_q           <= OPER_WIDTH'(gcd);
      coeff_larger_q  <= coeff_larger;
      coeff_smaller_q <= coeff_smaller;
      swapped_q       <= swapped;
    end
  end

  assign out_chan_o.valid            = out_valid_q;
  assign out_chan_o.gcd_value        = gcd_q;
  assign out_chan_o.coeff_larger     = coeff_larger_q;
  assign out_chan_o.coeff_smaller    = coeff_smaller_q;
  assign out_chan_o.operands_swapped = swapped_q;

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// extended gcd testbench
// drives operand pairs into extended_gcd, predicts the gcd, the bezout
// coefficients and the swap flag for every transfer, and checks each result
// in order; a directed table comes first, then three random phases with
// different idle patterns on both channels
// ----------------------------------------------------------------------------
module testbench;
  import egcd_pkg::*;

  localparam int DATA_WIDTH   = DATA_WIDTH_DEF;
  localparam int MAX_STEPS    = MAX_STEPS_DEF;
  localparam int N_DIRECTED   = 20;
  localparam int N_PER_PHASE  = 427;
  localparam int DRAIN_CYCLES = 2000;
  localparam int CYCLE_LIMIT  = 8_000_000;

  typedef logic [OPER_WIDTH-1:0]        opnd_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  typedef struct packed {
    opnd_t gcd_value;
    coef_t coeff_larger;
    coef_t coeff_smaller;
    logic  operands_swapped;
  } bezout_t;

  typedef struct packed {
    opnd_t   op_a;
    opnd_t   op_b;
    logic    has_want;
    bezout_t want;
  } pair_row_t;

  localparam opnd_t OPND_MAX = {OPER_WIDTH{1'b1}};

  // typed results only where they follow directly from the operands
  pair_row_t directed_rows [N_DIRECTED] = '{
    '{31'd0, 31'd0, 1'b1, '{31'd0, 32'sd1, 32'sd0, 1'b0}},
    '{OPND_MAX, 31'd0, 1'b1, '{OPND_MAX, 32'sd1, 32'sd0, 1'b0}},
    '{31'd0, OPND_MAX, 1'b1, '{OPND_MAX, 32'sd1, 32'sd0, 1'b1}},
    '{OPND_MAX, OPND_MAX, 1'b1, '{OPND_MAX, 32'sd0, 32'sd1, 1'b0}},
    '{31'd1, OPND_MAX, 1'b1, '{31'd1, 32'sd0, 32'sd1, 1'b1}},
    '{OPND_MAX, 31'd1, 1'b1, '{31'd1, 32'sd0, 32'sd1, 1'b0}},
    '{31'd1, 31'd1, 1'b1, '{31'd1, 32'sd0, 32'sd1, 1'b0}},
    '{31'd1, 31'd0, 1'b1, '{31'd1, 32'sd1, 32'sd0, 1'b0}},
    '{31'd0, 31'd1, 1'b1, '{31'd1, 32'sd1, 32'sd0, 1'b1}},
    '{OPND_MAX, OPND_MAX - 31'd1, 1'b1, '{31'd1, 32'sd1, -32'sd1, 1'b0}},
    '{31'h4000_0000, 31'h2000_0000, 1'b1, '{31'h2000_0000, 32'sd0, 32'sd1, 1'b0}},
    '{31'h4000_0000, 31'h4000_0000, 1'b1, '{31'h4000_0000, 32'sd0, 32'sd1, 1'b0}},
    // longest euclid chain that fits: consecutive fibonacci numbers
    '{31'd1836311903, 31'd1134903170, 1'b0, '0},
    '{31'd1134903170, 31'd1836311903, 1'b0, '0},
    '{31'h5555_5555, 31'h2AAA_AAAA, 1'b0, '0},
    '{31'd12, 31'd18, 1'b0, '0},
    '{31'd240, 31'd46, 1'b0, '0},
    '{31'h4000_0000, 31'd3, 1'b0, '0},
    '{31'd1000000007, 31'd998244353, 1'b0, '0},
    '{31'd7, 31'd86415, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  egcd_in_if  in_chan ();
  egcd_out_if out_chan ();

  extended_gcd #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_STEPS  (MAX_STEPS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan)
  );

  bezout_t     pending_results [$];
  logic        row_has_want;
  bezout_t     row_want;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_swapped;
  int unsigned n_cycles;
  int unsigned fib [47];

  function automatic bezout_t bezout_of(opnd_t op_a, opnd_t op_b);
    logic [63:0] mask;
    logic [63:0] r0, r1, x0, x1, y0, y1, q, t;
    int          steps;
    bezout_t     res;
    mask = (DATA_WIDTH >= 64) ? '1 : ((64'd1 << DATA_WIDTH) - 64'd1);
    res.operands_swapped = (64'(op_a) & mask) < (64'(op_b) & mask);
    r0 = res.operands_swapped ? 64'(op_b) & mask : 64'(op_a) & mask;
    r1 = res.operands_swapped ? 64'(op_a) & mask : 64'(op_b) & mask;
    x0 = 64'd1;
    x1 = 64'd0;
    y0 = 64'd0;
    y1 = 64'd1;
    steps = 0;
    // coefficients wrap modulo 2^64, only the low word is reported
    while (r1 != 64'd0 && steps < MAX_STEPS) begin
      q  = r0 / r1;
      t  = r0 % r1;
      r0 = r1;
      r1 = t;
      t  = x0 - q * x1;
      x0 = x1;
      x1 = t;
      t  = y0 - q * y1;
      y0 = y1;
      y1 = t;
      steps++;
    end
    res.gcd_value     = r0[OPER_WIDTH-1:0];
    res.coeff_larger  = x0[COEF_WIDTH-1:0];
    res.coeff_smaller = y0[COEF_WIDTH-1:0];
    return res;
  endfunction

  function automatic opnd_t rand_bits(int unsigned width);
    logic [31:0] raw;
    raw = $urandom;
    return opnd_t'(raw & ((32'd1 << width) - 32'd1));
  endfunction

  task automatic pick_pair(output opnd_t op_a, output opnd_t op_b);
    int unsigned kind;
    int unsigned k;
    opnd_t       tmp;
    kind = $urandom_range(99);
    if (kind < 30) begin
      op_a = rand_bits(OPER_WIDTH);
      op_b = rand_bits(OPER_WIDTH);
    end else if (kind < 65) begin
      // short operands keep the euclid chain short
      op_a = rand_bits($urandom_range(1, OPER_WIDTH));
      op_b = rand_bits($urandom_range(1, OPER_WIDTH));
    end else if (kind < 75) begin
      op_b = rand_bits($urandom_range(1, 15));
      op_a = opnd_t'(op_b * rand_bits($urandom_range(1, 15)));
    end else if (kind < 85) begin
      k = $urandom_range(1, 45);
      op_a = opnd_t'(fib[k + 1]);
      op_b = opnd_t'(fib[k]);
    end else if (kind < 92) begin
      op_a = rand_bits($urandom_range(1, OPER_WIDTH));
      op_b = op_a;
    end else begin
      op_a = rand_bits($urandom_range(1, OPER_WIDTH));
      op_b = '0;
    end
    if ($urandom_range(1) == 1) begin
      tmp  = op_a;
      op_a = op_b;
      op_b = tmp;
    end
  endtask

  // returns at the edge where the pair transfers, valid left high
  task automatic send_pair(opnd_t op_a, opnd_t op_b, logic has_want, bezout_t want);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_chan.valid          <= 1'b1;
    in_chan.first_operand  <= op_a;
    in_chan.second_operand <= op_b;
    row_has_want           <= has_want;
    row_want               <= want;
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic check_field(string name, longint want, longint seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      n_errors++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_chan.ready <= rst_ni && ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin : result_monitor
    bezout_t want;
    if (rst_ni) begin
      if (out_chan.valid && out_chan.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, actual gcd %0d", $time, out_chan.gcd_value);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("gcd_value", want.gcd_value, out_chan.gcd_value);
          check_field("coeff_larger", want.coeff_larger, out_chan.coeff_larger);
          check_field("coeff_smaller", want.coeff_smaller, out_chan.coeff_smaller);
          check_field("operands_swapped", want.operands_swapped,
                      out_chan.operands_swapped);
          n_checked++;
          if (out_chan.operands_swapped) n_swapped++;
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        pending_results.push_back(row_has_want ? row_want :
                                  bezout_of(in_chan.first_operand, in_chan.second_operand));
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    opnd_t op_a;
    opnd_t op_b;
    rst_ni                 = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.first_operand  = '0;
    in_chan.second_operand = '0;
    out_chan.ready         = 1'b0;
    row_has_want           = 1'b0;
    row_want               = '0;
    snd_idle_pct           = 6;
    rcv_idle_pct           = 61;
    n_errors               = 0;
    n_sent                 = 0;
    n_checked              = 0;
    n_swapped              = 0;
    n_cycles               = 0;
    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i < 47; i++) fib[i] = fib[i - 1] + fib[i - 2];

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pair(directed_rows[i].op_a, directed_rows[i].op_b,
                directed_rows[i].has_want, directed_rows[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 6;
          rcv_idle_pct = 61;
        end
        1: begin
          snd_idle_pct = 61;
          rcv_idle_pct = 6;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < N_PER_PHASE; i++) begin
        pick_pair(op_a, op_b);
        send_pair(op_a, op_b, 1'b0, '0);
      end
      // hold the sender until the block has drained
      in_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d operand pairs (%0d from the table), checked %0d results,",
             n_sent, N_DIRECTED, n_checked);
    $display("%0d of them with swapped operands, in %0d cycles", n_swapped, n_cycles);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
